// ----- hdl/shs_pkg.sv -----
// shared widths, codes and constants of the server health table
package shs_pkg;

  localparam int ActionW   = 3;
  localparam int SlotW     = 3;
  localparam int OffsetW   = 32;
  localparam int RttW      = 16;
  localparam int StratumW  = 8;
  localparam int FailW     = 8;
  localparam int ScoreW    = 19;
  localparam int AlphaW    = 9;
  localparam int PaddrW    = 3;
  localparam int PdataW    = 32;
  localparam int RegIdxBit = 2;

  // slot field reaches at most this many entries
  localparam int MaxSlots = 8;

  // multiply-add operand widths
  localparam int MacAW = 33;
  localparam int MacBW = 10;
  localparam int MacW  = 44;

  localparam logic [ActionW-1:0] ActAdd     = 3'd0;
  localparam logic [ActionW-1:0] ActRemove  = 3'd1;
  localparam logic [ActionW-1:0] ActSuccess = 3'd2;
  localparam logic [ActionW-1:0] ActFailure = 3'd3;
  localparam logic [ActionW-1:0] ActSelect  = 3'd4;
  localparam logic [ActionW-1:0] ActReset   = 3'd5;

  localparam logic RegAlpha = 1'b0;
  localparam logic RegLimit = 1'b1;

  localparam logic [AlphaW-1:0]   AlphaReset   = 9'd26;
  localparam logic [AlphaW-1:0]   AlphaMax     = 9'd256;
  localparam logic [FailW-1:0]    LimitReset   = 8'd3;
  localparam logic [FailW-1:0]    FailSat      = 8'd255;
  localparam logic [StratumW-1:0] StratumOnAdd = 8'd255;

  localparam logic [ScoreW-1:0] StratumWeight = 19'd1000;
  localparam logic [ScoreW-1:0] FailWeight    = 19'd100;

endpackage

// ----- hdl/shs_in_if.sv -----
// request channel of the server health table
interface shs_in_if import shs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ActionW-1:0]        action;
  logic [SlotW-1:0]          slot;
  logic signed [OffsetW-1:0] offset_ms;
  logic [RttW-1:0]           rtt_ms;
  logic [StratumW-1:0]       new_stratum;

  modport source (output valid, action, slot, offset_ms, rtt_ms, new_stratum, input ready);
  modport sink (input valid, action, slot, offset_ms, rtt_ms, new_stratum, output ready);
endinterface

// ----- hdl/shs_out_if.sv -----
// result channel of the server health table
interface shs_out_if import shs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      best_found;
  logic [SlotW-1:0]          best_slot;
  logic [ScoreW-1:0]         best_score;
  logic                      entry_reachable;
  logic [FailW-1:0]          entry_failures;
  logic [RttW-1:0]           entry_avg_rtt;
  logic signed [OffsetW-1:0] entry_avg_offset;

  modport source (output valid, best_found, best_slot, best_score, entry_reachable,
                  entry_failures, entry_avg_rtt, entry_avg_offset, input ready);
  modport sink (input valid, best_found, best_slot, best_score, entry_reachable,
                entry_failures, entry_avg_rtt, entry_avg_offset, output ready);
endinterface

// ----- hdl/shs_mac.sv -----
// shared multiply-add unit with registered result
module shs_mac import shs_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [MacAW-1:0]  mul_a_i,
  input  logic signed [MacBW-1:0]  mul_b_i,
  input  logic signed [MacW-1:0]   add_c_i,
  output logic signed [MacW-1:0]   prod_o
);

  logic signed [MacAW+MacBW-1:0] mul;
  logic signed [MacW-1:0]        prod_q;

  assign mul = mul_a_i * mul_b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= MacW'(mul) + add_c_i;
  end

  assign prod_o = prod_q;

endmodule

// ----- hdl/shs_scan.sv -----
// score of one entry per cycle, while step is high, against the running best
module shs_scan import shs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  logic                step_i,
  input  logic                elig_i,
  input  logic [SlotW-1:0]    slot_i,
  input  logic [StratumW-1:0] stratum_i,
  input  logic [FailW-1:0]    fails_i,
  input  logic [RttW-1:0]     rtt_i,
  output logic                found_o,
  output logic [SlotW-1:0]    slot_o,
  output logic [ScoreW-1:0]   score_o
);

  logic [ScoreW-1:0] score;
  logic              have_q;
  logic [SlotW-1:0]  slot_q;
  logic [ScoreW-1:0] best_q;

  assign score = ScoreW'(stratum_i) * StratumWeight + ScoreW'(fails_i) * FailWeight
               + ScoreW'(rtt_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      slot_q <= '0;
      best_q <= '0;
    end else if (clear_i) begin
      have_q <= 1'b0;
      slot_q <= '0;
      best_q <= '0;
    end else if (step_i && elig_i && (!have_q || score < best_q)) begin
      // strict compare keeps the lowest index on a tie
      have_q <= 1'b1;
      slot_q <= slot_i;
      best_q <= score;
    end
  end

  assign found_o = have_q;
  assign slot_o  = slot_q;
  assign score_o = best_q;

endmodule

// ----- hdl/server_health_table.sv -----
// top level: entry table, sequencer, config registers
// path to result valid: exec, report for add, remove, failure, reset statistics;
// exec, offset, round trip, report for success if the moving average runs twice
// through the shared multiply-add, else exec, report; exec, scan of every slot,
// report for select best; one item at a time, a new item is taken in the cycle
// after the result is taken; reset clears every entry, loads alpha 26, failure limit 3
module server_health_table import shs_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  shs_in_if.sink            in_ch_i,
  shs_out_if.source         out_ch_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  localparam int NumSlots = (ENTRIES < MaxSlots) ? ENTRIES : MaxSlots;
  localparam int IdxW     = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumSlots - 1);

  typedef enum logic [2:0] {
    StIdle, StExec, StOffset, StRtt, StScan, StReport, StHold
  } state_e;

  state_e state_q;

  logic [AlphaW-1:0] alpha_q;
  logic [FailW-1:0]  limit_q;

  // latched transaction
  logic [ActionW-1:0]        act_q;
  logic [SlotW-1:0]          slot_q;
  logic signed [OffsetW-1:0] in_off_q;
  logic [RttW-1:0]           in_rtt_q;
  logic [StratumW-1:0]       in_strat_q;

  // entry table
  logic                      present_q [NumSlots];
  logic                      reach_q   [NumSlots];
  logic [StratumW-1:0]       strat_q   [NumSlots];
  logic [FailW-1:0]          fail_q    [NumSlots];
  logic [RttW-1:0]           rtt_avg_q [NumSlots];
  logic signed [OffsetW-1:0] off_avg_q [NumSlots];

  logic [IdxW-1:0] cnt_q;

  logic                      out_valid_q;
  logic                      out_found_q;
  logic [SlotW-1:0]          out_bslot_q;
  logic [ScoreW-1:0]         out_bscore_q;
  logic                      out_reach_q;
  logic [FailW-1:0]          out_fail_q;
  logic [RttW-1:0]           out_rtt_q;
  logic signed [OffsetW-1:0] out_off_q;

  logic                      slot_ok;
  logic [IdxW-1:0]           idx;
  logic                      cur_present;
  logic                      cur_reach;
  logic [FailW-1:0]          cur_fail;
  logic [RttW-1:0]           cur_rtt;
  logic signed [OffsetW-1:0] cur_off;
  logic [FailW-1:0]          fail_inc;
  logic [AlphaW-1:0]         alpha_c;
  logic signed [MacAW-1:0]   mac_a;
  logic signed [MacBW-1:0]   mac_b;
  logic signed [MacW-1:0]    mac_c;
  logic signed [MacW-1:0]    mac_p;
  logic signed [MacW-1:0]    ema;
  logic                      cfg_wr;

  logic              scan_found;
  logic [SlotW-1:0]  scan_slot;
  logic [ScoreW-1:0] scan_score;

  assign slot_ok     = {1'b0, slot_q} < (SlotW+1)'(NumSlots);
  assign idx         = slot_q[IdxW-1:0];
  assign cur_present = present_q[idx];
  assign cur_reach   = reach_q[idx];
  assign cur_fail    = fail_q[idx];
  assign cur_rtt     = rtt_avg_q[idx];
  assign cur_off     = off_avg_q[idx];
  assign fail_inc    = (cur_fail == FailSat) ? cur_fail : cur_fail + FailW'(1);
  assign alpha_c     = (alpha_q > AlphaMax) ? AlphaMax : alpha_q;
  assign mac_b       = $signed({1'b0, alpha_c});

  // avg*256 + alpha*(sample - avg); offset pass in exec, round trip pass after
  always_comb begin
    if (state_q == StExec) begin
      mac_a = $signed({in_off_q[OffsetW-1], in_off_q}) - $signed({cur_off[OffsetW-1], cur_off});
      mac_c = $signed({{(MacW-OffsetW-8){cur_off[OffsetW-1]}}, cur_off, 8'd0});
    end else begin
      mac_a = $signed({{(MacAW-RttW){1'b0}}, in_rtt_q}) - $signed({{(MacAW-RttW){1'b0}}, cur_rtt});
      mac_c = $signed({{(MacW-RttW-8){1'b0}}, cur_rtt, 8'd0});
    end
  end

  shs_mac u_mac (
    .clk_i   (clk_i),
    .mul_a_i (mac_a),
    .mul_b_i (mac_b),
    .add_c_i (mac_c),
    .prod_o  (mac_p)
  );

  // divide by 256 truncating toward zero
  assign ema = mac_p[MacW-1] ? ((mac_p + MacW'(255)) >>> 8) : (mac_p >>> 8);

  shs_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (state_q == StExec),
    .step_i    (state_q == StScan),
    .elig_i    (present_q[cnt_q] & reach_q[cnt_q]),
    .slot_i    (SlotW'(cnt_q)),
    .stratum_i (strat_q[cnt_q]),
    .fails_i   (fail_q[cnt_q]),
    .rtt_i     (rtt_avg_q[cnt_q]),
    .found_o   (scan_found),
    .slot_o    (scan_slot),
    .score_o   (scan_score)
  );

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[RegIdxBit] == RegLimit) ? PdataW'(limit_q) : PdataW'(alpha_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      alpha_q      <= AlphaReset;
      limit_q      <= LimitReset;
      act_q        <= '0;
      slot_q       <= '0;
      in_off_q     <= '0;
      in_rtt_q     <= '0;
      in_strat_q   <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_found_q  <= 1'b0;
      out_bslot_q  <= '0;
      out_bscore_q <= '0;
      out_reach_q  <= 1'b0;
      out_fail_q   <= '0;
      out_rtt_q    <= '0;
      out_off_q    <= '0;
      for (int i = 0; i < NumSlots; i++) begin
        present_q[i] <= 1'b0;
        reach_q[i]   <= 1'b0;
        strat_q[i]   <= '0;
        fail_q[i]    <= '0;
        rtt_avg_q[i] <= '0;
        off_avg_q[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        if (paddr[RegIdxBit] == RegLimit) begin
          limit_q <= pwdata[FailW-1:0];
        end else begin
          alpha_q <= pwdata[AlphaW-1:0];
        end
      end

      unique case (state_q)
        StIdle: begin
          if (in_ch_i.valid) begin
            act_q      <= in_ch_i.action;
            slot_q     <= in_ch_i.slot;
            in_off_q   <= in_ch_i.offset_ms;
            in_rtt_q   <= in_ch_i.rtt_ms;
            in_strat_q <= in_ch_i.new_stratum;
            state_q    <= StExec;
          end
        end
        StExec: begin
          unique case (act_q)
            ActAdd: begin
              state_q <= StReport;
              if (slot_ok && !cur_present) begin
                present_q[idx] <= 1'b1;
                reach_q[idx]   <= 1'b1;
                strat_q[idx]   <= StratumOnAdd;
                fail_q[idx]    <= '0;
                rtt_avg_q[idx] <= '0;
                off_avg_q[idx] <= '0;
              end
            end
            ActRemove: begin
              state_q <= StReport;
              if (slot_ok) begin
                present_q[idx] <= 1'b0;
                reach_q[idx]   <= 1'b0;
                strat_q[idx]   <= '0;
                fail_q[idx]    <= '0;
                rtt_avg_q[idx] <= '0;
                off_avg_q[idx] <= '0;
              end
            end
            ActSuccess: begin
              if (slot_ok && cur_present && cur_off != '0) begin
                state_q <= StOffset;
              end else begin
                state_q <= StReport;
                if (slot_ok && cur_present) begin
                  // a zero offset average loads both averages directly from the sample
                  off_avg_q[idx] <= in_off_q;
                  rtt_avg_q[idx] <= in_rtt_q;
                  fail_q[idx]    <= '0;
                  strat_q[idx]   <= in_strat_q;
                end
              end
            end
            ActFailure: begin
              state_q <= StReport;
              if (slot_ok && cur_present) begin
                fail_q[idx] <= fail_inc;
                if (fail_inc >= limit_q) begin
                  reach_q[idx] <= 1'b0;
                end
              end
            end
            ActSelect: begin
              cnt_q   <= '0;
              state_q <= StScan;
            end
            ActReset: begin
              state_q <= StReport;
              for (int i = 0; i < NumSlots; i++) begin
                if (present_q[i]) begin
                  fail_q[i]    <= '0;
                  off_avg_q[i] <= '0;
                  rtt_avg_q[i] <= '0;
                  reach_q[i]   <= 1'b1;
                end
              end
            end
            default: begin
              state_q <= StReport;
            end
          endcase
        end
        StOffset: begin
          off_avg_q[idx] <= ema[OffsetW-1:0];
          state_q        <= StRtt;
        end
        StRtt: begin
          rtt_avg_q[idx] <= ema[RttW-1:0];
          fail_q[idx]    <= '0;
          strat_q[idx]   <= in_strat_q;
          state_q        <= StReport;
        end
        StScan: begin
          if (cnt_q == LastIdx) begin
            state_q <= StReport;
          end else begin
            cnt_q <= cnt_q + IdxW'(1);
          end
        end
        StReport: begin
          out_found_q  <= scan_found;
          out_bslot_q  <= scan_slot;
          out_bscore_q <= scan_score;
          out_reach_q  <= slot_ok ? cur_reach : 1'b0;
          out_fail_q   <= slot_ok ? cur_fail : '0;
          out_rtt_q    <= slot_ok ? cur_rtt : '0;
          out_off_q    <= slot_ok ? cur_off : '0;
          out_valid_q  <= 1'b1;
          state_q      <= StHold;
        end
        StHold: begin
          if (out_ch_o.ready) begin
            out_valid_q <= 1'b0;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_ch_i.ready = (state_q == StIdle);

  assign out_ch_o.valid            = out_valid_q;
  assign out_ch_o.best_found       = out_found_q;
  assign out_ch_o.best_slot        = out_bslot_q;
  assign out_ch_o.best_score       = out_bscore_q;
  assign out_ch_o.entry_reachable  = out_reach_q;
  assign out_ch_o.entry_failures   = out_fail_q;
  assign out_ch_o.entry_avg_rtt    = out_rtt_q;
  assign out_ch_o.entry_avg_offset = out_off_q;

endmodule
